@@ rtl/assert_macros.svh @@
// Assertion helper macros for the RTL files (included by dvp_ctrl)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

@@ rtl/dvp_pkg.sv @@
// ----------------------------------------------------------------------------
// dvp_pkg
// Shared types and constants for the dose-volume penalty stream core.
// ----------------------------------------------------------------------------
package dvp_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int MAX_VOXELS = 16777216;
    localparam int CNT_W      = 25;
    localparam int DIV_W      = 128;
    localparam int DIV_CNT_W  = 7;

    localparam logic [1:0] MODE_COST  = 2'd0;
    localparam logic [1:0] MODE_GRAD  = 2'd1;
    localparam logic [1:0] MODE_HESS  = 2'd2;
    localparam logic [1:0] MODE_PRICE = 2'd3;

    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_LIMIT  = 3'd1;
    localparam logic [2:0] REG_THRESH = 3'd2;
    localparam logic [2:0] REG_WEIGHT = 3'd3;
    localparam logic [2:0] REG_SKIP   = 3'd4;
    localparam logic [2:0] REG_TOTAL  = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_PREP,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic acc;
        logic prep;
        logic div_step;
        logic out_valid;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic counted;
        logic last;
        logic price;
        logic div_done;
    } status_t;

endpackage

@@ rtl/dvp_ctrl.sv @@
// ----------------------------------------------------------------------------
// dvp_ctrl
// Sequencer: accepts an item, steps the datapath, hands off any result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dvp_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  dvp_pkg::status_t  status,
    output dvp_pkg::cmd_t     cmd
);

    dvp_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dvp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dvp_pkg::ST_IDLE: begin
                if (s_valid) state_next = dvp_pkg::ST_MUL;
            end
            dvp_pkg::ST_MUL: begin
                state_next = dvp_pkg::ST_ACC;
            end
            dvp_pkg::ST_ACC: begin
                if ((status.counted && status.price) || (status.last && !status.price))
                    state_next = dvp_pkg::ST_PREP;
                else
                    state_next = dvp_pkg::ST_IDLE;
            end
            dvp_pkg::ST_PREP: begin
                state_next = dvp_pkg::ST_DIV;
            end
            dvp_pkg::ST_DIV: begin
                if (status.div_done) state_next = dvp_pkg::ST_OUT;
            end
            dvp_pkg::ST_OUT: begin
                if (m_ready) state_next = dvp_pkg::ST_IDLE;
            end
            default: state_next = dvp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            dvp_pkg::ST_IDLE: cmd.load = s_valid;
            dvp_pkg::ST_MUL:  cmd.mul = 1'b1;
            dvp_pkg::ST_ACC: begin
                cmd.acc = 1'b1;
                cmd.clear = status.last && (status.price || !status.last);
            end
            dvp_pkg::ST_PREP: cmd.prep = 1'b1;
            dvp_pkg::ST_DIV:  cmd.div_step = 1'b1;
            dvp_pkg::ST_OUT: begin
                cmd.out_valid = 1'b1;
                cmd.clear = m_ready && status.last;
            end
            default: cmd = '0;
        endcase
    end

    assign s_ready = (state_reg == dvp_pkg::ST_IDLE);
    assign m_valid = cmd.out_valid;

    `ASSERT_IMPL(a_ready_excl, aclk, aresetn, s_ready, !m_valid)
    `ASSERT_NEXT(a_load_mul, aclk, aresetn, s_valid && s_ready, state_reg == dvp_pkg::ST_MUL)
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid)

endmodule

@@ rtl/dvp_datapath.sv @@
// ----------------------------------------------------------------------------
// dvp_datapath
// Registers, term multiplier, saturating accumulator, restoring divider.
// ----------------------------------------------------------------------------
module dvp_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  dvp_pkg::cmd_t      cmd,
    output dvp_pkg::status_t   status,
    input  logic [1:0]         mode,
    input  logic               limit_kind,
    input  logic [31:0]        dose_threshold,
    input  logic [31:0]        penalty_weight,
    input  logic [24:0]        skip_count,
    input  logic [24:0]        voxel_total,
    input  logic [31:0]        s_dose_value,
    input  logic signed [31:0] s_factor_a,
    input  logic signed [31:0] s_factor_b,
    input  logic [23:0]        s_voxel_index,
    input  logic               s_last_item,
    output logic signed [63:0] m_result_value,
    output logic [23:0]        m_result_voxel,
    output logic               m_is_total,
    output logic               m_saturated
);

    logic [31:0] excess_reg;
    logic        viol_reg, last_reg, price_reg, counted_reg, neg_fa_reg;
    logic signed [31:0] fa_reg, fb_reg;
    logic [23:0] vidx_reg;
    logic [1:0]  mode_reg;
    logic [dvp_pkg::CNT_W-1:0] vcnt_reg;
    logic [63:0] term_reg;
    logic        term_sat_reg;
    logic signed [63:0] sum_reg;
    logic        sum_sat_reg;
    logic [dvp_pkg::DIV_W-1:0] dividend_reg, quot_reg;
    logic [63:0] rem_reg;
    logic [63:0] divisor_reg;
    logic [dvp_pkg::DIV_CNT_W-1:0] step_reg;
    logic        done_reg, neg_reg, sat_reg;
    logic [63:0] mag_reg, mult_reg;

    logic [24:0] skip_eff;
    logic [31:0] ex_lo, ex_hi;
    logic [31:0] fa_mag;
    logic signed [63:0] hess_prod;
    logic [63:0] rem_sh;
    logic [63:0] limit;
    logic [63:0] sum_mag;

    assign skip_eff = (skip_count > 25'(dvp_pkg::MAX_VOXELS)) ? 25'(dvp_pkg::MAX_VOXELS)
                                                               : skip_count;
    assign ex_lo = dose_threshold - s_dose_value;
    assign ex_hi = s_dose_value - dose_threshold;
    assign fa_mag = fa_reg[31] ? (32'd0 - fa_reg) : fa_reg;
    assign hess_prod = fa_reg * fb_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            excess_reg <= limit_kind ? ex_hi : ex_lo;
            viol_reg   <= limit_kind ? (s_dose_value > dose_threshold)
                                     : (s_dose_value < dose_threshold);
            fa_reg     <= s_factor_a;
            fb_reg     <= s_factor_b;
            vidx_reg   <= s_voxel_index;
            mode_reg   <= mode;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg <= 1'b0;
        end else if (cmd.load) begin
            last_reg <= s_last_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcnt_reg    <= '0;
            counted_reg <= 1'b0;
        end else if (cmd.mul) begin
            counted_reg <= 1'b0;
            if (viol_reg) begin
                if (vcnt_reg < skip_eff)
                    vcnt_reg <= vcnt_reg + 25'd1;
                else
                    counted_reg <= 1'b1;
            end
        end else if (cmd.clear) begin
            vcnt_reg <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            term_sat_reg <= 1'b0;
            neg_fa_reg   <= fa_reg[31];
            unique case (mode_reg)
                dvp_pkg::MODE_COST: begin
                    term_reg     <= {32'd0, excess_reg} * {32'd0, excess_reg};
                    term_sat_reg <= excess_reg > 32'hB504F333;
                end
                dvp_pkg::MODE_GRAD: term_reg <= {32'd0, excess_reg} * {32'd0, fa_mag};
                dvp_pkg::MODE_HESS: term_reg <= hess_prod;
                default:            term_reg <= {32'd0, excess_reg};
            endcase
        end
    end

    logic signed [63:0] term_s;
    logic signed [64:0] sum_w;
    always_comb begin
        if (mode_reg == dvp_pkg::MODE_COST)
            term_s = term_sat_reg ? 64'sh7FFFFFFFFFFFFFFF : $signed(term_reg);
        else if (mode_reg == dvp_pkg::MODE_GRAD)
            term_s = neg_fa_reg ? -$signed(term_reg) : $signed(term_reg);
        else
            term_s = $signed(term_reg);
        sum_w = {sum_reg[63], sum_reg} + {term_s[63], term_s};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg     <= '0;
            sum_sat_reg <= 1'b0;
        end else if (cmd.acc && counted_reg && mode_reg != dvp_pkg::MODE_PRICE) begin
            if (sum_w[64] != sum_w[63]) begin
                sum_reg     <= sum_w[64] ? 64'sh8000000000000000 : 64'sh7FFFFFFFFFFFFFFF;
                sum_sat_reg <= 1'b1;
            end else begin
                sum_reg     <= sum_w[63:0];
                sum_sat_reg <= sum_sat_reg | term_sat_reg;
            end
        end else if (cmd.clear) begin
            sum_reg     <= '0;
            sum_sat_reg <= 1'b0;
        end
    end

    logic [24:0] vt_eff;
    assign vt_eff  = (voxel_total == 25'd0) ? 25'd1 : voxel_total;
    assign sum_mag = sum_reg[63] ? (64'd0 - sum_reg) : sum_reg;

    logic price_now;
    assign price_now = (mode == dvp_pkg::MODE_PRICE);

    // operands registered in ACC; multiplied in PREP as two partial products over the 32-bit halves of the magnitude
    always_ff @(posedge aclk) begin
        if (cmd.acc) begin
            price_reg <= counted_reg && mode_reg == dvp_pkg::MODE_PRICE;
            if (counted_reg && mode_reg == dvp_pkg::MODE_PRICE) begin
                mag_reg     <= {32'd0, excess_reg};
                mult_reg    <= {31'd0, penalty_weight, 1'b0};
                neg_reg     <= limit_kind;
                divisor_reg <= {39'd0, vt_eff};
                sat_reg     <= 1'b0;
            end else begin
                mag_reg     <= sum_w[64] != sum_w[63] && counted_reg && !price_now
                               ? (sum_w[64] ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF)
                               : (counted_reg && !price_now ? (sum_w[63] ? 64'd0 - sum_w[63:0]
                               : sum_w[63:0]) : sum_mag);
                neg_reg     <= counted_reg && !price_now
                               ? (sum_w[64] != sum_w[63] ? sum_w[64] : sum_w[63])
                               : sum_reg[63];
                mult_reg    <= (mode == dvp_pkg::MODE_COST) ? {32'd0, penalty_weight}
                                                            : {31'd0, penalty_weight, 1'b0};
                divisor_reg <= {39'd0, vt_eff} << dvp_pkg::FRAC_BITS;
                sat_reg     <= sum_sat_reg | (counted_reg && !price_now &&
                               ((sum_w[64] != sum_w[63]) || term_sat_reg));
            end
        end
    end

    logic [64:0] pp_lo, pp_hi;
    assign pp_lo = mag_reg[31:0]  * mult_reg[32:0];
    assign pp_hi = mag_reg[63:32] * mult_reg[32:0];

    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            dividend_reg <= {63'd0, pp_lo} + ({63'd0, pp_hi} << 32);
            quot_reg     <= '0;
            rem_reg      <= '0;
            step_reg     <= '0;
            done_reg     <= 1'b0;
        end else if (cmd.div_step && !done_reg) begin
            dividend_reg <= dividend_reg << 1;
            if (rem_sh >= divisor_reg) begin
                rem_reg  <= rem_sh - divisor_reg;
                quot_reg <= {quot_reg[dvp_pkg::DIV_W-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh;
                quot_reg <= {quot_reg[dvp_pkg::DIV_W-2:0], 1'b0};
            end
            step_reg <= step_reg + 7'd1;
            done_reg <= (step_reg == 7'd127);
        end
    end

    assign rem_sh = {rem_reg[62:0], dividend_reg[dvp_pkg::DIV_W-1]};
    assign limit  = neg_reg ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF;

    logic q_ovf;
    logic [63:0] q_mag;
    assign q_ovf = (quot_reg[127:64] != 64'd0) || (quot_reg[63:0] > limit);
    assign q_mag = q_ovf ? limit : quot_reg[63:0];

    assign m_result_value = neg_reg ? $signed(64'd0 - q_mag) : $signed(q_mag);
    assign m_result_voxel = price_reg ? vidx_reg : 24'd0;
    assign m_is_total     = !price_reg;
    assign m_saturated    = sat_reg | q_ovf;

    assign status.counted  = counted_reg;
    assign status.last     = last_reg;
    assign status.price    = (mode_reg == dvp_pkg::MODE_PRICE);
    assign status.div_done = done_reg;

endmodule

@@ rtl/dose_volume_penalty_stream_core.sv @@
// ----------------------------------------------------------------------------
// dose_volume_penalty_stream_core
// Streaming dose-volume constraint penalty with APB configuration.
// ----------------------------------------------------------------------------
// Usage: program the six registers over APB while idle, then stream voxels
// on the s_ channel (valid/ready), last_item on the final one. Results leave
// on the m_ channel: one total per pass in modes 0..2, one price per
// counted voxel in mode 3.
// An item causing no result passes through load, multiply and accumulate.
// An item causing a result passes through load, multiply, accumulate,
// prepare, divide and output, where m_valid is raised. The normalization
// uses a 128-step restoring divider, one quotient bit per cycle.
// The result register holds while m_ready is low; no new transfer is taken
// until the result is delivered.
// Reset (synchronous, aresetn low) clears registers to their defaults,
// voxel_total to 1, and clears the counter and running sum.
// ----------------------------------------------------------------------------
module dose_volume_penalty_stream_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [31:0]        s_dose_value,
    input  logic signed [31:0] s_factor_a,
    input  logic signed [31:0] s_factor_b,
    input  logic [23:0]        s_voxel_index,
    input  logic               s_last_item,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [63:0] m_result_value,
    output logic [23:0]        m_result_voxel,
    output logic               m_is_total,
    output logic               m_saturated
);

    logic [1:0]  mode_reg;
    logic        limit_reg;
    logic [31:0] thresh_reg, weight_reg;
    logic [24:0] skip_reg, total_reg;
    logic [2:0]  reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= '0;
            limit_reg  <= 1'b0;
            thresh_reg <= '0;
            weight_reg <= '0;
            skip_reg   <= '0;
            total_reg  <= 25'd1;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                dvp_pkg::REG_MODE:   mode_reg   <= pwdata[1:0];
                dvp_pkg::REG_LIMIT:  limit_reg  <= pwdata[0];
                dvp_pkg::REG_THRESH: thresh_reg <= pwdata;
                dvp_pkg::REG_WEIGHT: weight_reg <= pwdata;
                dvp_pkg::REG_SKIP:   skip_reg   <= pwdata[24:0];
                dvp_pkg::REG_TOTAL:  total_reg  <= pwdata[24:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            dvp_pkg::REG_MODE:   prdata = {30'd0, mode_reg};
            dvp_pkg::REG_LIMIT:  prdata = {31'd0, limit_reg};
            dvp_pkg::REG_THRESH: prdata = thresh_reg;
            dvp_pkg::REG_WEIGHT: prdata = weight_reg;
            dvp_pkg::REG_SKIP:   prdata = {7'd0, skip_reg};
            dvp_pkg::REG_TOTAL:  prdata = {7'd0, total_reg};
            default:             prdata = '0;
        endcase
    end

    dvp_pkg::cmd_t    cmd;
    dvp_pkg::status_t status;

    dvp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    dvp_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .mode           (mode_reg),
        .limit_kind     (limit_reg),
        .dose_threshold (thresh_reg),
        .penalty_weight (weight_reg),
        .skip_count     (skip_reg),
        .voxel_total    (total_reg),
        .s_dose_value   (s_dose_value),
        .s_factor_a     (s_factor_a),
        .s_factor_b     (s_factor_b),
        .s_voxel_index  (s_voxel_index),
        .s_last_item    (s_last_item),
        .m_result_value (m_result_value),
        .m_result_voxel (m_result_voxel),
        .m_is_total     (m_is_total),
        .m_saturated    (m_saturated)
    );

endmodule
